// File: src/lhp_pkg.sv
// Shared constants, types and bucket arithmetic for the latency histogram unit.
package lhp_pkg;

    localparam int NUM_OP_TYPES = 8;
    localparam int BUCKET_TOTAL = 128;
    localparam int COUNT_WIDTH  = 32;

    localparam int OP_W     = 3;
    localparam int LAT_W    = 40;
    localparam int PCT_W    = 7;
    localparam int BKT_W    = 7;
    localparam int RANGE_W  = 27;
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 64;

    localparam int B_SUBMS = 10;
    localparam int B_MS    = 99;
    localparam int B_HMS   = 9;
    localparam int B_SEC   = 9;

    localparam int SUBMS_US    = 100;
    localparam int MS_US       = 1000;
    localparam int HMS_US      = 100000;
    localparam int SEC_US      = 1000000;
    localparam int MS_LIMIT_US = 100000;
    localparam int HMS_LIMIT   = 1000000;
    localparam int SEC_LIMIT   = 10000000;
    localparam int OVF_HIGH_US = 100000000;
    localparam int PCT_MAX     = 100;

    localparam int MS_SHIFT  = 27;
    localparam int MS_RECIP  = 134218;
    localparam int MS_PROD_W = 35;

    localparam int BKT_DEPTH = NUM_OP_TYPES * BUCKET_TOTAL;
    localparam int BKT_AW    = (BKT_DEPTH > 1) ? $clog2(BKT_DEPTH) : 1;
    localparam int STAT_AW   = (NUM_OP_TYPES > 1) ? $clog2(NUM_OP_TYPES) : 1;
    localparam int PROD_W    = COUNT_WIDTH + PCT_W;
    localparam int CUM_W     = COUNT_WIDTH + 14;
    localparam int STAT_W    = COUNT_WIDTH + LAT_W + SUM_W;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] n;
        logic [LAT_W-1:0]       mx;
        logic [SUM_W-1:0]       sum;
    } t_stats;

    typedef struct packed {
        logic [BKT_W-1:0] bkt;
        t_stats           st;
    } t_result;

    typedef struct packed {
        logic [BKT_W-1:0]    bkt;
        logic [RANGE_W-1:0]  lo;
        logic [RANGE_W-1:0]  hi;
        logic [SAMPLE_W-1:0] n;
        logic [LAT_W-1:0]    mx;
        logic [SUM_W-1:0]    sum;
    } t_out;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [BKT_W-1:0] lat_to_bucket(input logic [LAT_W-1:0] lat);
        logic [3:0]           cnt;
        logic [MS_PROD_W-1:0] prod;
        logic [BKT_W-1:0]     b;
        int                   k;
        cnt  = '0;
        prod = MS_PROD_W'(lat[16:0]) * MS_PROD_W'(MS_RECIP);
        if (lat < LAT_W'(MS_US)) begin
            for (k = 1; k < B_SUBMS; k++) begin
                cnt = cnt + 4'(lat >= LAT_W'(k * SUBMS_US));
            end
            b = BKT_W'(cnt);
        end else if (lat < LAT_W'(MS_LIMIT_US)) begin
            b = BKT_W'(prod >> MS_SHIFT) + BKT_W'(B_SUBMS - 1);
        end else if (lat < LAT_W'(HMS_LIMIT)) begin
            for (k = 1; k <= B_HMS; k++) begin
                cnt = cnt + 4'(lat >= LAT_W'(k * HMS_US));
            end
            b = BKT_W'(B_SUBMS + B_MS - 1) + BKT_W'(cnt);
        end else if (lat < LAT_W'(SEC_LIMIT)) begin
            for (k = 1; k <= B_SEC; k++) begin
                cnt = cnt + 4'(lat >= LAT_W'(k * SEC_US));
            end
            b = BKT_W'(B_SUBMS + B_MS + B_HMS - 1) + BKT_W'(cnt);
        end else begin
            b = BKT_W'(BUCKET_TOTAL - 1);
        end
        return b;
    endfunction

    function automatic logic [RANGE_W-1:0] bucket_lo(input logic [BKT_W-1:0] b);
        logic [RANGE_W-1:0] lo;
        if (b < BKT_W'(B_SUBMS)) begin
            lo = RANGE_W'(b) * RANGE_W'(SUBMS_US);
        end else if (b < BKT_W'(B_SUBMS + B_MS)) begin
            lo = RANGE_W'(b - BKT_W'(B_SUBMS - 1)) * RANGE_W'(MS_US);
        end else if (b < BKT_W'(B_SUBMS + B_MS + B_HMS)) begin
            lo = RANGE_W'(b - BKT_W'(B_SUBMS + B_MS - 1)) * RANGE_W'(HMS_US);
        end else if (b < BKT_W'(B_SUBMS + B_MS + B_HMS + B_SEC)) begin
            lo = RANGE_W'(b - BKT_W'(B_SUBMS + B_MS + B_HMS - 1)) * RANGE_W'(SEC_US);
        end else begin
            lo = RANGE_W'(SEC_LIMIT);
        end
        return lo;
    endfunction

    function automatic logic [RANGE_W-1:0] bucket_hi(input logic [BKT_W-1:0] b);
        return (b == BKT_W'(BUCKET_TOTAL - 1)) ? RANGE_W'(OVF_HIGH_US)
                                               : bucket_lo(b + BKT_W'(1));
    endfunction

    function automatic logic [BKT_AW-1:0] bkt_addr(input logic [OP_W-1:0] t,
                                                   input logic [BKT_W-1:0] idx);
        return BKT_AW'(BKT_AW'(t) * BKT_AW'(BUCKET_TOTAL) + BKT_AW'(idx));
    endfunction

endpackage

// File: src/lhp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/latency_histogram_percentile_unit.sv
// Top level: per-type latency histograms in RAM with record and percentile query.
// Record: accept with bucket and stats read, then write-back.
// Query: accept with stats read, then a walk up to k, the index of the answering
//   bucket (0 to 127), one bucket per cycle over the bucket RAM read port.
// Held output register: wait in a push state until it frees, one cycle or more.
// Reset: synchronous; then a clearing pass over all 1024 bucket entries (one per cycle).
module latency_histogram_percentile_unit
    import lhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    input  logic [OP_W-1:0]     i_op_type,
    input  logic [LAT_W-1:0]    i_latency_us,
    input  logic [PCT_W-1:0]    i_percentile,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [BKT_W-1:0]    o_bucket_index,
    output logic [RANGE_W-1:0]  o_range_low_us,
    output logic [RANGE_W-1:0]  o_range_high_us,
    output logic [SAMPLE_W-1:0] o_sample_count,
    output logic [LAT_W-1:0]    o_max_latency_us,
    output logic [SUM_W-1:0]    o_latency_sum_us
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_REC   = 3'd2;
    localparam logic [2:0] S_QSTAT = 3'd3;
    localparam logic [2:0] S_QWALK = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [BKT_AW-1:0] r_clr;
    logic [OP_W-1:0]   r_t;
    logic              r_tvalid;
    logic [LAT_W-1:0]  r_lat;
    logic [PCT_W-1:0]  r_pct;
    logic [BKT_W-1:0]  r_bkt;
    logic [BKT_W-1:0]  r_didx;
    logic [CUM_W-1:0]  r_cum;
    logic [PROD_W-1:0] r_prod;
    t_stats            r_stat;
    t_result           r_pend;
    t_out              r_out;
    logic              r_ovalid;

    logic                   accept, out_free, clearing, in_tvalid;
    logic [BKT_W-1:0]       in_bkt;
    logic                   bkt_we;
    logic [BKT_AW-1:0]      bkt_raddr, bkt_waddr;
    logic [COUNT_WIDTH-1:0] bkt_wdata, bkt_rdata;
    logic                   st_we;
    logic [STAT_AW-1:0]     st_raddr, st_waddr;
    logic [STAT_W-1:0]      st_wdata, st_rdata;
    t_stats                 st_rd, upd;
    logic [SUM_W:0]         sum_add;
    logic [COUNT_WIDTH-1:0] qn;
    logic [CUM_W-1:0]       cum_nx;
    logic                   hit, walk_done, fin, out_load;
    t_result                res, out_src;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_ovalid || !i_stall;
    assign clearing  = (r_state == S_CLEAR);
    assign in_tvalid = int'(i_op_type) < NUM_OP_TYPES;
    assign in_bkt    = lat_to_bucket(i_latency_us);
    assign st_rd     = t_stats'(st_rdata);

    lhp_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BKT_DEPTH)) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    lhp_ram #(.WIDTH(STAT_W), .DEPTH(NUM_OP_TYPES)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        upd.n   = sat_inc(st_rd.n);
        upd.mx  = (r_lat > st_rd.mx) ? r_lat : st_rd.mx;
        sum_add = (SUM_W + 1)'(st_rd.sum) + (SUM_W + 1)'(r_lat);
        upd.sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        qn      = r_tvalid ? st_rd.n : '0;

        case (r_state)
            S_QSTAT: bkt_raddr = bkt_addr(r_t, '0);
            S_QWALK: bkt_raddr = bkt_addr(r_t, r_didx + BKT_W'(1));
            default: bkt_raddr = bkt_addr(i_op_type, in_bkt);
        endcase
        st_raddr = STAT_AW'(i_op_type);

        bkt_we    = clearing || ((r_state == S_REC) && r_tvalid);
        bkt_waddr = clearing ? r_clr : bkt_addr(r_t, r_bkt);
        bkt_wdata = clearing ? '0 : sat_inc(bkt_rdata);
        st_we     = (clearing && (int'(r_clr) < NUM_OP_TYPES))
                    || ((r_state == S_REC) && r_tvalid);
        st_waddr  = clearing ? STAT_AW'(r_clr) : STAT_AW'(r_t);
        st_wdata  = clearing ? '0 : upd;

        cum_nx    = r_cum + CUM_W'(bkt_rdata) * CUM_W'(PCT_MAX);
        hit       = !r_tvalid || (CUM_W'(r_prod) < cum_nx + CUM_W'(PCT_MAX));
        walk_done = hit || (r_didx == BKT_W'(BUCKET_TOTAL - 1));

        if (r_state == S_REC) begin
            res.bkt = r_bkt;
            res.st  = r_tvalid ? upd : '0;
        end else begin
            res.bkt = r_didx;
            res.st  = r_stat;
        end
        fin      = (r_state == S_REC) || ((r_state == S_QWALK) && walk_done);
        out_load = (fin || (r_state == S_PUSH)) && out_free;
        out_src  = (r_state == S_PUSH) ? r_pend : res;

        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == BKT_AW'(BKT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_cmd == CMD_QUERY) ? S_QSTAT : S_REC;
                end
            end
            S_REC: begin
                n_state = out_free ? S_IDLE : S_PUSH;
            end
            S_QSTAT: begin
                n_state = S_QWALK;
            end
            S_QWALK: begin
                if (walk_done) begin
                    n_state = out_free ? S_IDLE : S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr <= r_clr + BKT_AW'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t      <= i_op_type;
            r_tvalid <= in_tvalid;
            r_lat    <= i_latency_us;
            r_pct    <= (i_percentile > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : i_percentile;
            r_bkt    <= in_bkt;
        end
        if (r_state == S_QSTAT) begin
            r_stat <= r_tvalid ? st_rd : '0;
            r_prod <= PROD_W'(r_pct) * PROD_W'(qn);
            r_cum  <= '0;
            r_didx <= '0;
        end
        if ((r_state == S_QWALK) && !walk_done) begin
            r_didx <= r_didx + BKT_W'(1);
            r_cum  <= cum_nx;
        end
        if (fin && !out_free) begin
            r_pend <= res;
        end
        if (out_load) begin
            r_out.bkt <= out_src.bkt;
            r_out.lo  <= bucket_lo(out_src.bkt);
            r_out.hi  <= bucket_hi(out_src.bkt);
            r_out.n   <= SAMPLE_W'(out_src.st.n);
            r_out.mx  <= out_src.st.mx;
            r_out.sum <= out_src.st.sum;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_bucket_index   = r_out.bkt;
    assign o_range_low_us   = r_out.lo;
    assign o_range_high_us  = r_out.hi;
    assign o_sample_count   = r_out.n;
    assign o_max_latency_us = r_out.mx;
    assign o_latency_sum_us = r_out.sum;

endmodule

// File: src/lhp_checker.sv
// Port-level checker for the latency histogram unit, bound to the top level.
module lhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_cmd,
    input logic [2:0]  i_op_type,
    input logic [39:0] i_latency_us,
    input logic [6:0]  i_percentile,
    input logic        o_valid,
    input logic        i_stall,
    input logic [6:0]  o_bucket_index,
    input logic [26:0] o_range_low_us,
    input logic [26:0] o_range_high_us,
    input logic [31:0] o_sample_count,
    input logic [39:0] o_max_latency_us,
    input logic [63:0] o_latency_sum_us
);

    assert property (@(posedge i_clk) !i_rst_n |=> o_stall && !o_valid)
        else $error("reset must stall input and drop output valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("an accepted item must keep the input stalled for a cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bucket_index)
            && $stable(o_latency_sum_us) && $stable(o_sample_count))
        else $error("stalled result item changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_range_low_us < o_range_high_us)
        else $error("bucket bounds out of order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bucket_index == 7'd127 |-> o_range_high_us == 27'd100000000)
        else $error("overflow bucket upper bound wrong");

endmodule

bind latency_histogram_percentile_unit lhp_checker u_lhp_checker (.*);
